FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the de-esser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a generic failure message.
`define SDE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("de-esser assertion failed");

// Clocked assertion with a caller-supplied message string.
`define SDE_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/core/sde_pkg.sv
// Types, constants and tables shared by the stereo de-esser modules.
package sde_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int FILT_W     = 28;
  localparam int COEF_FRAC  = 22;
  localparam int LOG_BITS   = 8;
  localparam int LOG_SIZE   = 1 << LOG_BITS;
  localparam int STEP_W     = $clog2(LOG_BITS);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [31:0] DB_PER_OCT = 32'd394566;
  localparam logic [31:0] OCT_PER_DB = 32'd10885;
  localparam int          FLOOR_DB   = -30720;
  localparam logic [30:0] UNITY      = 31'h4000_0000;
  localparam logic [16:0] UNIT_Q16   = 17'd65536;

  localparam logic signed [63:0] SMP_MAX  = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SMP_MIN  = -SMP_MAX - 64'sd1;
  localparam logic signed [63:0] FILT_MAX = (64'sd1 <<< (FILT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] FILT_MIN = -FILT_MAX - 64'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_B0       = 4'd0,
    REG_BAND_A1       = 4'd1,
    REG_BAND_A2       = 4'd2,
    REG_ATTACK_COEFF  = 4'd3,
    REG_RELEASE_COEFF = 4'd4,
    REG_THRESHOLD_DB  = 4'd5,
    REG_AMOUNT        = 4'd6,
    REG_MIX           = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [21:0] band_b0;
    logic signed [23:0] band_a1;
    logic        [21:0] band_a2;
    logic        [16:0] attack_coeff;
    logic        [16:0] release_coeff;
    logic signed [14:0] threshold_db;
    logic        [16:0] amount;
    logic        [16:0] mix;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } pair_t;

  // 2^(-2^-i) in Q1.30 for the fraction bits of the gain exponent.
  localparam logic [30:0] EXP_STEPS [LOG_BITS] = '{
    31'd759250125, 31'd902905651, 31'd984625594, 31'd1028218693,
    31'd1050733751, 31'd1062175491, 31'd1067942999, 31'd1070838487
  };

  typedef logic [15:0] log_rom_t [LOG_SIZE];

  // log2(1 + idx/2^LOG_BITS) in Q0.16 by repeated squaring in Q1.30.
  function automatic logic [15:0] log_entry(input int unsigned idx);
    logic [63:0] x;
    logic [15:0] r;
    x = (64'd1 << 30) + (64'(idx) << (30 - LOG_BITS));
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t t;
    for (int i = 0; i < LOG_SIZE; i++) begin
      t[i] = log_entry(i);
    end
    return t;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

  function automatic logic [16:0] clamp_unit(input logic [16:0] v);
    return (v > UNIT_Q16) ? UNIT_Q16 : v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > SMP_MAX) ? SMP_MAX : ((v < SMP_MIN) ? SMP_MIN : v);
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > FILT_MAX) ? FILT_MAX : ((v < FILT_MIN) ? FILT_MIN : v);
    return r[FILT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/sde_ifs.sv
// Handshake interfaces for the sample, result and configuration channels.
interface sde_in_if import sde_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface sde_out_if import sde_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface sde_cfg_if import sde_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/stereo_de_esser_unit.sv
// Top level of the stereo de-esser: configuration, input queue and processing core.
//
// Usage. Sample pairs (left_in, right_in, signed Q1.23) arrive as beats on in_ch_i and
// processed pairs leave as beats on out_ch_o, one result beat per input beat, in order.
// Registers are written through cfg_i, one register per beat, index 0 to 7; a beat with
// a higher index is taken and ignored. cfg_i is always ready; write only while idle.
// Input beats land in a queue of QUEUE_DEPTH pairs, so the source keeps sending while
// the core works and while a finished pair waits in the output register.
// Processing: the core handles one pair at a time, both channels in turn through one
// shared 32x32 multiplier. A channel takes a shorter path when its envelope sits at
// or below the threshold than when it is reduced (the gain is built over eight
// multiply steps). A result beat waits longer when pairs are queued ahead of it.
// Reset sets all registers to their defaults and clears filter and envelope history.
// When the receiver stalls the result holds on out_ch_o, the core finishes at most one
// more pair and waits, and the queue fills before in_ch_i drops ready.
module stereo_de_esser_unit import sde_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sde_cfg_if.sink   cfg_i,
  sde_in_if.sink    in_ch_i,
  sde_out_if.source out_ch_o
);

  cfg_t  cfg;
  logic  q_valid;
  pair_t q_data;
  logic  q_pop;

  // Register file; values feed the core directly.
  sde_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Front end queue decouples the source from the core.
  sde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch_i),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  // Processing core with its own output register.
  sde_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_ch_o  (out_ch_o)
  );

endmodule

FILE: rtl/core/sde_cfg_regs.sv
// Configuration register file of the de-esser.
module sde_cfg_regs import sde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sde_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.band_b0       <= 22'd630076;
      regs_q.band_a1       <= -24'sd5040590;
      regs_q.band_a2       <= 22'd2934170;
      regs_q.attack_coeff  <= 17'd6483;
      regs_q.release_coeff <= 17'd272;
      regs_q.threshold_db  <= -15'sd5120;
      regs_q.amount        <= 17'd32768;
      regs_q.mix           <= 17'd65536;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_BAND_B0:       regs_q.band_b0       <= cfg_i.data[21:0];
        REG_BAND_A1:       regs_q.band_a1       <= cfg_i.data[23:0];
        REG_BAND_A2:       regs_q.band_a2       <= cfg_i.data[21:0];
        REG_ATTACK_COEFF:  regs_q.attack_coeff  <= cfg_i.data[16:0];
        REG_RELEASE_COEFF: regs_q.release_coeff <= cfg_i.data[16:0];
        REG_THRESHOLD_DB:  regs_q.threshold_db  <= cfg_i.data[14:0];
        REG_AMOUNT:        regs_q.amount        <= cfg_i.data[16:0];
        REG_MIX:           regs_q.mix           <= cfg_i.data[16:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/sde_queue.sv
// Front end: accepts sample pairs into a short queue ahead of the processing core.
module sde_queue import sde_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  sde_in_if.sink  in_ch_i,
  output logic    valid_o,
  output pair_t   data_o,
  input  logic    pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pair_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           push, pop;

  assign in_ch_i.ready = (cnt_q != CW'(DEPTH));
  assign push          = in_ch_i.valid && in_ch_i.ready;
  assign valid_o       = (cnt_q != '0);
  assign pop           = pop_i && valid_o;
  assign data_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{left: in_ch_i.left_in, right: in_ch_i.right_in};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/sde_mul.sv
// Shared signed multiplier with a registered product.
module sde_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

endmodule

FILE: rtl/core/sde_core.sv
// Back end: sequences filter, envelope, log, gain and mix over one shared multiplier.
module sde_core import sde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  pair_t     q_data_i,
  output logic      q_pop_o,
  sde_out_if.source out_ch_o
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_F_B0   = 5'd1;
  localparam logic [4:0] ST_F_A1   = 5'd2;
  localparam logic [4:0] ST_F_A2   = 5'd3;
  localparam logic [4:0] ST_F_SUM  = 5'd4;
  localparam logic [4:0] ST_F_OUT  = 5'd5;
  localparam logic [4:0] ST_E_MUL  = 5'd6;
  localparam logic [4:0] ST_E_UPD  = 5'd7;
  localparam logic [4:0] ST_L_NORM = 5'd8;
  localparam logic [4:0] ST_L_MUL  = 5'd9;
  localparam logic [4:0] ST_L_DB   = 5'd10;
  localparam logic [4:0] ST_R_CMP  = 5'd11;
  localparam logic [4:0] ST_R_AMT  = 5'd12;
  localparam logic [4:0] ST_R_OCT  = 5'd13;
  localparam logic [4:0] ST_R_EXP  = 5'd14;
  localparam logic [4:0] ST_G_MUL  = 5'd15;
  localparam logic [4:0] ST_G_UPD  = 5'd16;
  localparam logic [4:0] ST_G_SHFT = 5'd17;
  localparam logic [4:0] ST_W_MUL  = 5'd18;
  localparam logic [4:0] ST_W_MIX  = 5'd19;
  localparam logic [4:0] ST_W_OUT  = 5'd20;
  localparam logic [4:0] ST_PUSH   = 5'd21;

  logic [4:0]                 state_q;
  logic                       chan_q;
  pair_t                      item_q;
  logic signed [SAMPLE_W-1:0] x1_q [2];
  logic signed [SAMPLE_W-1:0] x2_q [2];
  logic signed [FILT_W-1:0]   y1_q [2];
  logic signed [FILT_W-1:0]   y2_q [2];
  logic [SAMPLE_W-1:0]        env_q [2];

  logic signed [63:0]         acc_q;
  logic [SAMPLE_W-1:0]        mag_q;
  logic [4:0]                 msb_q;
  logic [LOG_BITS-1:0]        mant_q;
  logic                       envz_q;
  logic signed [17:0]         db_q;
  logic [17:0]                ex3_q;
  logic [15:0]                frac_q;
  logic [4:0]                 shift_q;
  logic                       gz_q;
  logic [STEP_W-1:0]          k_q;
  logic [30:0]                gain_q;
  logic signed [SAMPLE_W-1:0] res_l_q;
  logic                       ov_q;
  logic signed [SAMPLE_W-1:0] out_l_q, out_r_q;

  logic signed [31:0]         mul_a, mul_b;
  logic signed [63:0]         prod;

  logic signed [SAMPLE_W-1:0] x_cur;
  logic [SAMPLE_W-1:0]        env_cur;
  logic signed [63:0]         y_full;
  logic signed [FILT_W-1:0]   y_new;
  logic [FILT_W-1:0]          y_abs;
  logic [SAMPLE_W-1:0]        mag_c;
  logic [16:0]                coef_c;
  logic signed [SAMPLE_W:0]   delta_c;
  logic signed [SAMPLE_W:0]   xdiff_c;
  logic signed [63:0]         env_full;
  logic [4:0]                 msb_c;
  logic [SAMPLE_W-1:0]        norm_c;
  logic signed [31:0]         lv_c;
  logic signed [63:0]         db_full;
  logic signed [17:0]         ex_diff;
  logic [17:0]                ex3_c;
  logic [3:0]                 fbit_idx;
  logic [30:0]                step_c;
  logic signed [63:0]         wet_full, wdiff_full, out_full;

  sde_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign q_pop_o            = (state_q == ST_IDLE) && q_valid_i;
  assign out_ch_o.valid     = ov_q;
  assign out_ch_o.left_out  = out_l_q;
  assign out_ch_o.right_out = out_r_q;

  always_comb begin
    x_cur    = chan_q ? item_q.right : item_q.left;
    env_cur  = env_q[chan_q];
    xdiff_c  = (SAMPLE_W + 1)'(x_cur) - (SAMPLE_W + 1)'(x2_q[chan_q]);
    y_full   = (acc_q + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    y_new    = sat_filt(y_full);
    y_abs    = y_new[FILT_W-1] ? FILT_W'(-y_new) : FILT_W'(y_new);
    mag_c    = (|y_abs[FILT_W-1:SAMPLE_W]) ? '1 : y_abs[SAMPLE_W-1:0];
    coef_c   = (mag_q > env_cur) ? clamp_unit(cfg_i.attack_coeff)
                                 : clamp_unit(cfg_i.release_coeff);
    delta_c  = $signed({1'b0, mag_q}) - $signed({1'b0, env_cur});
    env_full = $signed({40'b0, env_cur}) + (prod >>> 16);
    msb_c    = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (env_cur[i]) msb_c = 5'(i);
    end
    norm_c   = env_cur << (5'(SAMPLE_W - 1) - msb_c);
    lv_c     = ((32'(msb_q) - 32'(SAMPLE_W - 1)) << 16) + 32'(LOG_ROM[mant_q]);
    db_full  = prod >>> 24;
    ex_diff  = db_q - 18'(cfg_i.threshold_db);
    ex3_c    = {ex_diff[16:0], 1'b0} + ex_diff;
    fbit_idx = 4'd15 - 4'(k_q);
    step_c   = frac_q[fbit_idx] ? EXP_STEPS[k_q] : UNITY;
    wet_full   = prod >>> 30;
    wdiff_full = wet_full - 64'(x_cur);
    out_full   = 64'(x_cur) + (prod >>> 16);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_F_B0:  begin mul_a = 32'(cfg_i.band_b0);           mul_b = 32'(xdiff_c);      end
      ST_F_A1:  begin mul_a = 32'(cfg_i.band_a1);           mul_b = 32'(y1_q[chan_q]); end
      ST_F_A2:  begin mul_a = 32'(cfg_i.band_a2);           mul_b = 32'(y2_q[chan_q]); end
      ST_E_MUL: begin mul_a = 32'(coef_c);                  mul_b = 32'(delta_c);      end
      ST_L_MUL: begin mul_a = lv_c;                         mul_b = DB_PER_OCT;        end
      ST_R_AMT: begin mul_a = 32'(ex3_q);                   mul_b = 32'(clamp_unit(cfg_i.amount)); end
      ST_R_OCT: begin mul_a = 32'(prod[32:16]);             mul_b = OCT_PER_DB;        end
      ST_G_MUL: begin mul_a = 32'(gain_q);                  mul_b = 32'(step_c);       end
      ST_W_MUL: begin mul_a = 32'(x_cur);                   mul_b = 32'(gain_q);       end
      ST_W_MIX: begin
        mul_a = 32'(clamp_unit(cfg_i.mix));
        mul_b = 32'($signed(wdiff_full[SAMPLE_W:0]));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE:   if (q_valid_i) item_q <= q_data_i;
      ST_F_A1:   acc_q <= prod;
      ST_F_A2:   acc_q <= acc_q - prod;
      ST_F_SUM:  acc_q <= acc_q - prod;
      ST_F_OUT:  mag_q <= mag_c;
      ST_L_NORM: begin
        msb_q  <= msb_c;
        mant_q <= norm_c[SAMPLE_W-2 -: LOG_BITS];
        envz_q <= (env_cur == '0);
      end
      ST_L_DB:   db_q <= envz_q ? 18'(FLOOR_DB) : db_full[17:0];
      ST_R_CMP:  begin
        ex3_q  <= ex3_c;
        gain_q <= UNITY;
      end
      ST_R_EXP:  begin
        frac_q  <= prod[23:8];
        shift_q <= prod[28:24];
        gz_q    <= (prod[30:24] >= 7'd31);
        gain_q  <= UNITY;
        k_q     <= '0;
      end
      ST_G_UPD:  begin
        gain_q <= prod[60:30];
        k_q    <= k_q + STEP_W'(1);
      end
      ST_G_SHFT: gain_q <= gz_q ? '0 : (gain_q >> shift_q);
      ST_W_OUT:  if (!chan_q) res_l_q <= sat_sample(out_full);
      ST_PUSH:   if (!ov_q || out_ch_o.ready) begin
        out_l_q <= res_l_q;
        out_r_q <= item_q.right;
      end
      default: ;
    endcase
    // The right result rides in item_q.right once that channel is done.
    if (state_q == ST_W_OUT && chan_q) item_q.right <= sat_sample(out_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= 1'b0;
      ov_q    <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        x1_q[c]  <= '0;
        x2_q[c]  <= '0;
        y1_q[c]  <= '0;
        y2_q[c]  <= '0;
        env_q[c] <= '0;
      end
    end else begin
      if (ov_q && out_ch_o.ready) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (q_valid_i) begin
          chan_q  <= 1'b0;
          state_q <= ST_F_B0;
        end
        ST_F_B0:  state_q <= ST_F_A1;
        ST_F_A1:  state_q <= ST_F_A2;
        ST_F_A2:  state_q <= ST_F_SUM;
        ST_F_SUM: state_q <= ST_F_OUT;
        ST_F_OUT: begin
          x2_q[chan_q] <= x1_q[chan_q];
          x1_q[chan_q] <= x_cur;
          y2_q[chan_q] <= y1_q[chan_q];
          y1_q[chan_q] <= y_new;
          state_q      <= ST_E_MUL;
        end
        ST_E_MUL: state_q <= ST_E_UPD;
        ST_E_UPD: begin
          env_q[chan_q] <= env_full[SAMPLE_W-1:0];
          state_q       <= ST_L_NORM;
        end
        ST_L_NORM: state_q <= ST_L_MUL;
        ST_L_MUL:  state_q <= ST_L_DB;
        ST_L_DB:   state_q <= ST_R_CMP;
        ST_R_CMP:  state_q <= (db_q > 18'(cfg_i.threshold_db)) ? ST_R_AMT : ST_W_MUL;
        ST_R_AMT:  state_q <= ST_R_OCT;
        ST_R_OCT:  state_q <= ST_R_EXP;
        ST_R_EXP:  state_q <= ST_G_MUL;
        ST_G_MUL:  state_q <= ST_G_UPD;
        ST_G_UPD:  state_q <= (k_q == STEP_W'(LOG_BITS - 1)) ? ST_G_SHFT : ST_G_MUL;
        ST_G_SHFT: state_q <= ST_W_MUL;
        ST_W_MUL:  state_q <= ST_W_MIX;
        ST_W_MIX:  state_q <= ST_W_OUT;
        ST_W_OUT: begin
          if (!chan_q) begin
            chan_q  <= 1'b1;
            state_q <= ST_F_B0;
          end else begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: if (!ov_q || out_ch_o.ready) begin
          ov_q    <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/sde_checker.sv
// Port-level checker for the stereo de-esser and its bind to the top level.
`include "assert_macros.svh"

module sde_checker #(
  parameter int LIMIT = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_left,
  input logic [23:0] out_right
);

  localparam int PW = $clog2(LIMIT + 2);

  logic [PW-1:0] pending_q;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + PW'(1);
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - PW'(1);
    end
  end

  `SDE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid)
  `SDE_ASSERT_MSG(a_out_stable, clk_i, rst_ni, out_valid && !out_ready |=> $stable(out_left) && $stable(out_right), "stalled result changed")
  `SDE_ASSERT_MSG(a_no_phantom, clk_i, rst_ni, out_valid |-> pending_q != '0, "result without input")
  `SDE_ASSERT(a_bounded, clk_i, rst_ni, pending_q <= PW'(LIMIT))

endmodule

bind stereo_de_esser_unit sde_checker #(.LIMIT(QUEUE_DEPTH + 2)) u_sde_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch_i.valid),
  .in_ready  (in_ch_i.ready),
  .out_valid (out_ch_o.valid),
  .out_ready (out_ch_o.ready),
  .out_left  (out_ch_o.left_out),
  .out_right (out_ch_o.right_out)
);

FILE: bench/tb_top.sv
// Self-checking testbench for the stereo de-esser: directed, register and random sample tests.
module tb_top;
  import sde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 1000000;
  localparam int END_WAIT  = 200;

  // Gain steps 2^(-2^-i) in Q1.30, one per fraction bit of the exponent.
  localparam longint ATTEN_STEP [8] = '{
    759250125, 902905651, 984625594, 1028218693,
    1050733751, 1062175491, 1067942999, 1070838487
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  sde_cfg_if cfg_ch ();
  sde_in_if  in_ch ();
  sde_out_if out_ch ();

  stereo_de_esser_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_ch),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  // Shadow copy of the registers and the per-channel history of the block.
  longint sh_b0, sh_a1, sh_a2, sh_att, sh_rel, sh_thr, sh_amt, sh_mix;
  longint x_d1 [2];
  longint x_d2 [2];
  longint y_d1 [2];
  longint y_d2 [2];
  longint env_lvl [2];
  longint log_frac_rom [LOG_SIZE];

  pair_t  pending_pairs [$];
  int     mismatch_cnt = 0;
  int     checked_cnt = 0;
  int     sent_cnt = 0;
  int     cycle_cnt = 0;
  int     hold_off = 0;
  bit     no_idle = 1'b0;

  // The source of one part of the table: log2(1 + idx/256) by repeated squaring.
  function automatic longint log2_frac(longint idx);
    longint unsigned x;
    longint r;
    x = (64'd1 << 30) + (longint'(idx) << (30 - LOG_BITS));
    r = 0;
    for (int i = 15; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r = r | (64'd1 << i);
      end
    end
    return r;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
  endfunction

  function automatic longint unit_clip(longint v);
    return (v > 65536) ? 64'sd65536 : v;
  endfunction

  function automatic longint sign_ext(longint v, int bits);
    longint m;
    m = (64'sd1 <<< bits) - 1;
    v = v & m;
    if (v[bits-1]) v = v - (64'sd1 <<< bits);
    return v;
  endfunction

  // Envelope level to Q8.8 dB; an empty envelope sits at the floor.
  function automatic longint level_to_db(longint lvl);
    int msb;
    longint mant;
    if (lvl == 0) return FLOOR_DB;
    msb = 0;
    for (int i = 0; i < 64; i++) if (lvl[i]) msb = i;
    if (msb >= LOG_BITS) mant = (lvl >> (msb - LOG_BITS)) & (LOG_SIZE - 1);
    else mant = (lvl << (LOG_BITS - msb)) & (LOG_SIZE - 1);
    return ((longint'(msb - (SAMPLE_W - 1)) * 65536 + log_frac_rom[mant]) * 394566) >>> 24;
  endfunction

  // Linear gain 2^-(e/2^16) in Q1.30.
  function automatic longint atten_gain(longint e);
    longint n, f, g;
    n = e >>> 16;
    f = e & 16'hFFFF;
    g = 64'sd1 <<< 30;
    for (int i = 1; i <= LOG_BITS; i++)
      if ((f >> (16 - i)) & 1) g = (g * ATTEN_STEP[i-1]) >>> 30;
    return (n >= 31) ? 64'sd0 : (g >>> n);
  endfunction

  function automatic longint deess_channel(int c, longint x);
    longint acc, y, mag, coef, db, g, wet, outv, red;
    acc = sh_b0 * x - sh_b0 * x_d2[c] - sh_a1 * y_d1[c] - sh_a2 * y_d2[c];
    y = clip((acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC, FILT_W);
    x_d2[c] = x_d1[c];
    x_d1[c] = x;
    y_d2[c] = y_d1[c];
    y_d1[c] = y;
    mag = (y < 0) ? -y : y;
    if (mag > (64'sd1 <<< SAMPLE_W) - 1) mag = (64'sd1 <<< SAMPLE_W) - 1;
    coef = unit_clip((mag > env_lvl[c]) ? sh_att : sh_rel);
    env_lvl[c] = env_lvl[c] + (((mag - env_lvl[c]) * coef) >>> 16);
    db = level_to_db(env_lvl[c]);
    g = 64'sd1 <<< 30;
    if (db > sh_thr) begin
      red = ((db - sh_thr) * unit_clip(sh_amt) * 3) >>> 16;
      g = atten_gain((red * 10885) >>> 8);
    end
    wet = (x * g) >>> 30;
    outv = x + ((unit_clip(sh_mix) * (wet - x)) >>> 16);
    return clip(outv, SAMPLE_W);
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    longint v;
    v = longint'(d);
    case (idx)
      REG_BAND_B0:       sh_b0 = v & 22'h3FFFFF;
      REG_BAND_A1:       sh_a1 = sign_ext(v, 24);
      REG_BAND_A2:       sh_a2 = v & 22'h3FFFFF;
      REG_ATTACK_COEFF:  sh_att = v & 17'h1FFFF;
      REG_RELEASE_COEFF: sh_rel = v & 17'h1FFFF;
      REG_THRESHOLD_DB:  sh_thr = sign_ext(v, 15);
      REG_AMOUNT:        sh_amt = v & 17'h1FFFF;
      REG_MIX:           sh_mix = v & 17'h1FFFF;
      default: ;
    endcase
  endfunction

  // Sends one stereo beat and records what the block should answer.
  task automatic send_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
    pair_t p;
    int gap;
    if (!no_idle && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(12, 1);
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    p.left  = SAMPLE_W'(deess_channel(0, longint'(l)));
    p.right = SAMPLE_W'(deess_channel(1, longint'(r)));
    pending_pairs.push_back(p);
    sent_cnt++;
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    shadow_write(idx, d);
    cfg_ch.valid <= 1'b0;
  endtask

  // A sample with a random amplitude class so the envelope swings across the threshold.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int sh;
    logic [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom);
    sh = $urandom_range(3) == 0 ? 0 : $urandom_range(20);
    return $signed(raw) >>> sh;
  endfunction

  task automatic write_all_random();
    write_reg(REG_BAND_B0, CFG_DATA_W'($urandom_range(1500000)));
    write_reg(REG_BAND_A1, CFG_DATA_W'(-$urandom_range(7000000, 3000000)));
    write_reg(REG_BAND_A2, CFG_DATA_W'($urandom_range(3800000, 2000000)));
    write_reg(REG_ATTACK_COEFF, CFG_DATA_W'($urandom_range(70000)));
    write_reg(REG_RELEASE_COEFF, CFG_DATA_W'($urandom_range(70000)));
    write_reg(REG_THRESHOLD_DB, CFG_DATA_W'(-$urandom_range(10240)));
    write_reg(REG_AMOUNT, CFG_DATA_W'($urandom_range(70000)));
    write_reg(REG_MIX, CFG_DATA_W'($urandom_range(70000)));
  endtask

  // Extremes of both sample fields under the reset defaults.
  task automatic test_field_extremes();
    send_pair(24'sh7FFFFF, 24'sh800000);
    send_pair(24'sh800000, 24'sh7FFFFF);
    send_pair(24'sh000000, 24'sh000000);
    send_pair(24'shFFFFFF, 24'sh000001);
    send_pair(24'sh7FFFFF, 24'sh7FFFFF);
    send_pair(24'sh800000, 24'sh800000);
    send_pair(24'sh555555, 24'shAAAAAA);
    send_pair(24'shAAAAAA, 24'sh555555);
    drain();
  endtask

  // Special cases: threshold above zero, huge reduction, filter overflow, unused index.
  task automatic test_special_cases();
    write_reg(REG_THRESHOLD_DB, 24'h003FFF);
    send_pair(24'sh7FFFFF, 24'sh800000);
    send_pair(24'sh800000, 24'sh7FFFFF);
    drain();
    // Full attack, maximum amount and a low threshold drive a strong gain reduction.
    write_reg(REG_THRESHOLD_DB, -24'sd10240);
    write_reg(REG_AMOUNT, 24'h01FFFF);
    write_reg(REG_ATTACK_COEFF, 24'h01FFFF);
    write_reg(REG_RELEASE_COEFF, 24'd0);
    write_reg(REG_MIX, 24'd0);
    send_pair(24'sh7FFFFF, 24'sh800000);
    drain();
    write_reg(REG_MIX, 24'h01FFFF);
    for (int i = 0; i < 4; i++) send_pair(i[0] ? 24'sh7FFFFF : 24'sh800000, 24'sh7FFFFF);
    drain();
    // Largest feedback makes the filter output run into saturation.
    write_reg(REG_BAND_B0, 24'h3FFFFF);
    write_reg(REG_BAND_A1, 24'h800000);
    write_reg(REG_BAND_A2, 24'h3FFFFF);
    for (int i = 0; i < 5; i++) send_pair(24'sh7FFFFF, 24'sh800000);
    drain();
    write_reg(4'd8, 24'hFFFFFF);
    write_reg(4'd15, 24'h000000);
    write_reg(REG_BAND_A1, 24'h7FFFFF);
    write_reg(REG_BAND_B0, 24'd0);
    write_reg(REG_BAND_A2, 24'd0);
    send_pair(24'sh123456, -24'sh123456);
    send_pair(24'sh7FFFFF, 24'sh800000);
    drain();
  endtask

  // Several register settings, each followed by a burst of random pairs.
  task automatic test_random_phases(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph == 0) begin
        write_reg(REG_BAND_B0, 24'd630076);
        write_reg(REG_BAND_A1, -24'sd5040590);
        write_reg(REG_BAND_A2, 24'd2934170);
        write_reg(REG_ATTACK_COEFF, 24'd6483);
        write_reg(REG_RELEASE_COEFF, 24'd272);
        write_reg(REG_THRESHOLD_DB, -24'sd5120);
        write_reg(REG_AMOUNT, 24'd32768);
        write_reg(REG_MIX, 24'd65536);
      end else begin
        write_all_random();
      end
      no_idle = (ph == 1);
      for (int i = 0; i < per_phase; i++) begin
        // Occasional raw full-scale noise next to the shaped samples.
        if ($urandom_range(9) == 0) send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        else send_pair(rand_sample(), rand_sample());
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the queue fills.
  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 12; i++) send_pair(rand_sample(), rand_sample());
    drain();
  endtask

  // Result side: checks each beat and idles ready at random.
  always @(posedge clk_i) begin
    pair_t exp_p;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pairs.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Unexpected result beat %h %h",
                                         out_ch.left_out, out_ch.right_out);
      end else begin
        exp_p = pending_pairs.pop_front();
        checked_cnt++;
        if (out_ch.left_out !== exp_p.left || out_ch.right_out !== exp_p.right) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Mismatch on result %0d: expected %h %h, got %h %h", checked_cnt,
                     exp_p.left, exp_p.right, out_ch.left_out, out_ch.right_out);
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < LOG_SIZE; i++) log_frac_rom[i] = log2_frac(i);
    sh_b0 = 630076; sh_a1 = -5040590; sh_a2 = 2934170; sh_att = 6483;
    sh_rel = 272; sh_thr = -5120; sh_amt = 32768; sh_mix = 65536;
    for (int c = 0; c < 2; c++) begin
      x_d1[c] = 0; x_d2[c] = 0; y_d1[c] = 0; y_d2[c] = 0; env_lvl[c] = 0;
    end
    in_ch.valid = 1'b0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_special_cases();
    test_random_phases(10, 100);
    test_backpressure();
    test_random_phases(1, 40);

    drain();
    repeat (END_WAIT) @(posedge clk_i);
    $display("Covered %0d stereo beats over many register settings with random stalls.",
             sent_cnt);
    $display("Compared %0d result beats, %0d mismatches.", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_pairs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
